[src/ufv_pkg.sv]
// ----------------------------------------------------------------------------
// ufv_pkg
// Shared types and constants for the UTF-8 filename validator.
// ----------------------------------------------------------------------------
package ufv_pkg;

    // Item kinds carried in tuser
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_END  = 1'b1;

    localparam int unsigned DATA_W  = 8;
    localparam int unsigned COUNT_W = 9;
    localparam int unsigned POINT_W = 21;
    localparam int unsigned MIN_W   = 17;
    localparam int unsigned CONT_W  = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;
    localparam logic [DATA_W-1:0]  MAX_BYTES_RST = 8'd255;

    // Special bytes
    localparam logic [DATA_W-1:0] CH_SPACE = 8'h20;
    localparam logic [DATA_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [DATA_W-1:0] CH_SLASH = 8'h2f;
    localparam logic [DATA_W-1:0] CH_BSL   = 8'h5c;

    // Lead byte ranges
    localparam logic [DATA_W-1:0] LEAD2_LO = 8'hc2;
    localparam logic [DATA_W-1:0] LEAD2_HI = 8'hdf;
    localparam logic [DATA_W-1:0] LEAD3_LO = 8'he0;
    localparam logic [DATA_W-1:0] LEAD3_HI = 8'hef;
    localparam logic [DATA_W-1:0] LEAD4_LO = 8'hf0;
    localparam logic [DATA_W-1:0] LEAD4_HI = 8'hf4;

    // Minimum code points per sequence length
    localparam logic [MIN_W-1:0] MIN2 = 17'h00080;
    localparam logic [MIN_W-1:0] MIN3 = 17'h00800;
    localparam logic [MIN_W-1:0] MIN4 = 17'h10000;

    localparam logic [POINT_W-1:0] POINT_MAX = 21'h10ffff;
    localparam logic [POINT_W-1:0] SURR_LO   = 21'h00d800;
    localparam logic [POINT_W-1:0] SURR_HI   = 21'h00dfff;
    localparam logic [POINT_W-1:0] CTRL_LIM  = 21'd32;
    localparam logic [POINT_W-1:0] C1_LO     = 21'd127;
    localparam logic [POINT_W-1:0] C1_HI     = 21'd159;

    // One input beat as seen by the checker
    typedef struct packed {
        logic              valid;
        logic              action;
        logic [DATA_W-1:0] data_byte;
    } ufv_step_t;

    // Status from the checker
    typedef struct packed {
        logic empty;    // no byte seen since last verdict
        logic failed;   // sticky failure flag
    } ufv_status_t;

    // True when a completed code point is not allowed in a name
    function automatic logic point_bad(input logic [POINT_W-1:0] p,
                                       input logic [MIN_W-1:0]   minimum);
        logic bad;
        bad = (p < {4'd0, minimum}) || (p > POINT_MAX)
           || ((p >= SURR_LO) && (p <= SURR_HI))
           || (p < CTRL_LIM)
           || ((p >= C1_LO) && (p <= C1_HI));
        return bad;
    endfunction

endpackage

[src/utf8_filename_validator_top.sv]
// ----------------------------------------------------------------------------
// utf8_filename_validator_top
// Path: a verdict reaches m_axis through the input register, then the result
// register, after the edge that accepts its end-of-name beat.
// Throughput: one beat per cycle, set by the input register and the
// registered state update in the checker. An end-of-name beat waits in the
// input register only while the result register is full and not taken.
// Reset: synchronous active-low aresetn clears all name state and sets the
// length limit to 255; no clearing pass.
// ----------------------------------------------------------------------------
module utf8_filename_validator_top
    import ufv_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // input stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] data_byte
    input  logic              s_axis_tuser,   // [0] action
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [7:0]        m_axis_tdata,   // [0] name_valid, [7:1] zero
    // configuration
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [7:0]        cfg_data        // max_name_bytes
);

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [DATA_W-1:0] in_byte_reg;
    logic              out_valid_reg;
    logic              out_bit_reg;
    logic [DATA_W-1:0] max_reg;
    logic              out_free;
    logic              proc;
    logic              verdict;
    ufv_step_t         step;
    ufv_status_t       status;

    // Handshake
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && ((in_action_reg == ACT_BYTE) || out_free);
    assign s_axis_tready = !in_valid_reg || proc;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_bit_reg};

    assign step.valid     = proc;
    assign step.action    = in_action_reg;
    assign step.data_byte = in_byte_reg;

    ufv_check u_check (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .max_bytes (max_reg),
        .verdict   (verdict),
        .status    (status)
    );

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_action_reg <= s_axis_tuser;
            in_byte_reg   <= s_axis_tdata;
        end
    end

    // Result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (proc && (in_action_reg == ACT_END)) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc && (in_action_reg == ACT_END)) begin
            out_bit_reg <= verdict;
        end
    end

    // Length limit register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_reg <= MAX_BYTES_RST;
        end else if (cfg_valid && cfg_ready) begin
            max_reg <= cfg_data;
        end
    end

    // Checks
    a_rise_from_end: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(proc && (in_action_reg == ACT_END)))
        else $error("result appeared without an end-of-name beat");

    a_clear_after_verdict: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc && (in_action_reg == ACT_END)) |=> (status.empty && !status.failed))
        else $error("name state not cleared after verdict");

    a_stall_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> (in_valid_reg && out_valid_reg && !m_axis_tready))
        else $error("input stalled without a full result register");

endmodule

[src/ufv_check.sv]
// ----------------------------------------------------------------------------
// ufv_check
// Running filename state: UTF-8 decode, character rules, length count and
// the verdict for an end-of-name beat. State clears after each verdict.
// ----------------------------------------------------------------------------
module ufv_check
    import ufv_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  ufv_step_t           step,
    input  logic [DATA_W-1:0]   max_bytes,
    output logic                verdict,
    output ufv_status_t         status
);

    logic [COUNT_W-1:0] count_reg,   count_next;
    logic               failed_reg,  failed_next;
    logic [CONT_W-1:0]  cont_reg,    cont_next;
    logic [POINT_W-1:0] point_reg,   point_next;
    logic [MIN_W-1:0]   minpt_reg,   minpt_next;
    logic               space_reg,   space_next;
    logic               dots_reg,    dots_next;

    // Verdict from current state
    assign verdict = !failed_reg
                  && (count_reg != '0)
                  && (count_reg <= {1'b0, max_bytes})
                  && (cont_reg == '0)
                  && !space_reg
                  && !(dots_reg && ((count_reg == 9'd1) || (count_reg == 9'd2)));

    assign status.empty  = (count_reg == '0);
    assign status.failed = failed_reg;

    // Next state
    always_comb begin
        logic [DATA_W-1:0]  b;
        logic [POINT_W-1:0] shifted;
        b          = step.data_byte;
        shifted    = {point_reg[POINT_W-7:0], b[5:0]};
        count_next = count_reg;
        failed_next = failed_reg;
        cont_next  = cont_reg;
        point_next = point_reg;
        minpt_next = minpt_reg;
        space_next = space_reg;
        dots_next  = dots_reg;
        if (step.valid && (step.action == ACT_END)) begin
            count_next  = '0;
            failed_next = 1'b0;
            cont_next   = '0;
            point_next  = '0;
            minpt_next  = '0;
            space_next  = 1'b0;
            dots_next   = 1'b1;
        end else if (step.valid) begin
            // name-level rules
            if ((count_reg == '0) && (b == CH_SPACE)) failed_next = 1'b1;
            if ((b == CH_SLASH) || (b == CH_BSL))     failed_next = 1'b1;
            if (b != CH_DOT) dots_next = 1'b0;
            space_next = (b == CH_SPACE);
            if (count_reg != COUNT_MAX) count_next = count_reg + 9'd1;

            // UTF-8 decode
            if (cont_reg != '0) begin
                if (b[7:6] != 2'b10) begin
                    failed_next = 1'b1;
                    cont_next   = '0;
                end else begin
                    point_next = shifted;
                    cont_next  = cont_reg - 2'd1;
                    if ((cont_reg == 2'd1) && point_bad(shifted, minpt_reg))
                        failed_next = 1'b1;
                end
            end else if ((b >= LEAD2_LO) && (b <= LEAD2_HI)) begin
                point_next = {16'd0, b[4:0]};
                minpt_next = MIN2;
                cont_next  = 2'd1;
            end else if ((b >= LEAD3_LO) && (b <= LEAD3_HI)) begin
                point_next = {17'd0, b[3:0]};
                minpt_next = MIN3;
                cont_next  = 2'd2;
            end else if ((b >= LEAD4_LO) && (b <= LEAD4_HI)) begin
                point_next = {18'd0, b[2:0]};
                minpt_next = MIN4;
                cont_next  = 2'd3;
            end else if (b[7]) begin
                failed_next = 1'b1;
            end else if (point_bad({13'd0, b}, '0)) begin
                failed_next = 1'b1;
            end
        end
    end

    // State registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg  <= '0;
            failed_reg <= 1'b0;
            cont_reg   <= '0;
            point_reg  <= '0;
            minpt_reg  <= '0;
            space_reg  <= 1'b0;
            dots_reg   <= 1'b1;
        end else begin
            count_reg  <= count_next;
            failed_reg <= failed_next;
            cont_reg   <= cont_next;
            point_reg  <= point_next;
            minpt_reg  <= minpt_next;
            space_reg  <= space_next;
            dots_reg   <= dots_next;
        end
    end

endmodule
